/* design/fdat_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the fixed decimal amount to text block.
// No dependencies.
package fdat_pkg;

    localparam int AMOUNT_W        = 64;
    localparam int BCD_DIGITS      = 21;
    localparam int INTEGER_DIGITS  = 13;
    localparam int FRACTION_DIGITS = 8;
    localparam int MAX_RESULTS     = 22;
    localparam int BCD_W           = BCD_DIGITS * 4;
    localparam int BITS_PER_STAGE  = 4;
    localparam int DABBLE_STAGES   = AMOUNT_W / BITS_PER_STAGE;
    localparam int SLOTS           = INTEGER_DIGITS + 1 + FRACTION_DIGITS;
    localparam int IDX_W           = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CHAR_W          = 6;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_POINT = 6'd46;

    typedef logic [BCD_W-1:0]    bcd_t;
    typedef logic [AMOUNT_W-1:0] amount_t;
    typedef logic [IDX_W-1:0]    idx_t;

    typedef struct packed {
        bcd_t    bcd;
        amount_t bin;
    } dabble_t;

    typedef struct packed {
        logic [SLOTS-1:0][CHAR_W-1:0] slots;
        idx_t                         first_idx;
        idx_t                         last_idx;
    } text_t;

    // Digit at position pos, position 0 being the most significant.
    function automatic logic [3:0] digit_at(bcd_t bcd, int pos);
        logic [3:0] d;
        d = 4'd0;
        if (pos < BCD_DIGITS)
        begin
            d = bcd[(BCD_DIGITS - 1 - pos) * 4 +: 4];
        end
        return d;
    endfunction

endpackage

/* design/fdat_dabble_stage.sv */
`timescale 1ns / 1ps
// One register stage of the double dabble pipeline: BITS_PER_STAGE shift-and-add-3 steps.
// Depends on fdat_pkg.
module fdat_dabble_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fdat_pkg::dabble_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output fdat_pkg::dabble_t out_data
);

    logic              valid_reg;
    fdat_pkg::dabble_t data_reg;
    fdat_pkg::dabble_t data_next;

    always_comb
    begin
        fdat_pkg::bcd_t    bcd;
        fdat_pkg::amount_t bin;
        bcd = in_data.bcd;
        bin = in_data.bin;
        for (int k = 0; k < fdat_pkg::BITS_PER_STAGE; k++)
        begin
            for (int g = 0; g < fdat_pkg::BCD_DIGITS; g++)
            begin
                if (bcd[g * 4 +: 4] >= 4'd5)
                begin
                    bcd[g * 4 +: 4] = bcd[g * 4 +: 4] + 4'd3;
                end
            end
            bcd = {bcd[fdat_pkg::BCD_W-2:0], bin[fdat_pkg::AMOUNT_W-1]};
            bin = {bin[fdat_pkg::AMOUNT_W-2:0], 1'b0};
        end
        data_next.bcd = bcd;
        data_next.bin = bin;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* design/fdat_format.sv */
`timescale 1ns / 1ps
// Formatting stage: builds the character slots and the first and last slot of the text.
// Depends on fdat_pkg.
module fdat_format (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fdat_pkg::bcd_t    in_bcd,
    output logic              out_valid,
    input  logic              out_ready,
    output fdat_pkg::text_t   out_text
);

    logic            valid_reg;
    fdat_pkg::text_t text_reg;
    fdat_pkg::text_t text_next;

    always_comb
    begin
        int         first_pos;
        int         last_pos;
        int         last_nz;
        logic       any_frac;
        logic [3:0] d;
        first_pos = fdat_pkg::INTEGER_DIGITS - 1;
        last_nz   = 0;
        any_frac  = 1'b0;
        text_next.slots = '0;
        for (int p = fdat_pkg::INTEGER_DIGITS - 1; p >= 0; p--)
        begin
            d = fdat_pkg::digit_at(in_bcd, p);
            text_next.slots[p] = fdat_pkg::ASCII_ZERO + {2'b00, d};
            if (d != 4'd0)
            begin
                first_pos = p;
            end
        end
        text_next.slots[fdat_pkg::INTEGER_DIGITS] = fdat_pkg::ASCII_POINT;
        for (int p = 0; p < fdat_pkg::FRACTION_DIGITS; p++)
        begin
            d = fdat_pkg::digit_at(in_bcd, fdat_pkg::INTEGER_DIGITS + p);
            text_next.slots[fdat_pkg::INTEGER_DIGITS + 1 + p] =
                fdat_pkg::ASCII_ZERO + {2'b00, d};
            if (d != 4'd0)
            begin
                last_nz  = p;
                any_frac = 1'b1;
            end
        end
        last_pos = any_frac ? (fdat_pkg::INTEGER_DIGITS + 1 + last_nz)
                            : (fdat_pkg::INTEGER_DIGITS - 1);
        // run length cap
        if (last_pos - first_pos >= fdat_pkg::MAX_RESULTS)
        begin
            last_pos = first_pos + fdat_pkg::MAX_RESULTS - 1;
        end
        text_next.first_idx = fdat_pkg::IDX_W'(first_pos);
        text_next.last_idx  = fdat_pkg::IDX_W'(last_pos);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            text_reg <= text_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_text  = text_reg;

endmodule

/* design/fdat_serial.sv */
`timescale 1ns / 1ps
// Serializer: walks the character slots of one request and drives the output register.
// Depends on fdat_pkg.
module fdat_serial (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fdat_pkg::text_t               in_text,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fdat_pkg::CHAR_W-1:0]   out_char,
    output logic                          out_last
);

    logic                                  busy_reg;
    fdat_pkg::idx_t                        idx_reg;
    fdat_pkg::idx_t                        last_idx_reg;
    logic [fdat_pkg::SLOTS-1:0][fdat_pkg::CHAR_W-1:0] slots_reg;
    logic                                  valid_reg;
    logic [fdat_pkg::CHAR_W-1:0]           char_reg;
    logic                                  last_reg;
    logic                                  fire;
    logic                                  at_last;

    assign fire     = busy_reg && (!valid_reg || out_ready);
    assign at_last  = (idx_reg == last_idx_reg);
    assign in_ready = !busy_reg || (fire && at_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                busy_reg <= 1'b1;
            end
            else if (fire && at_last)
            begin
                busy_reg <= 1'b0;
            end
            if (fire)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            slots_reg    <= in_text.slots;
            idx_reg      <= in_text.first_idx;
            last_idx_reg <= in_text.last_idx;
        end
        else if (fire)
        begin
            idx_reg <= idx_reg + fdat_pkg::IDX_W'(1);
        end
        if (fire)
        begin
            char_reg <= slots_reg[idx_reg];
            last_reg <= at_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

/* design/fixed_decimal_amount_to_text.sv */
`timescale 1ns / 1ps
// Top level: 64-bit amount (1e-8 units) to ASCII decimal text, one character per beat.
// A request passes through 16 dabble stages, the format stage, the serializer load and the
// output registers before its first character. Its text is 1..21 characters, sent one per
// cycle by the serializer while m_tready holds; later requests can be taken meanwhile and wait in the stages.
// Reset: asynchronous active-low rst_n clears all valid and busy flags; no other state.
// Depends on fdat_pkg, fdat_dabble_stage, fdat_format, fdat_serial.
module fixed_decimal_amount_to_text (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] amount
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] character, [7:6] zero
    output logic        m_tlast
);

    logic                  stg_valid [fdat_pkg::DABBLE_STAGES+1];
    logic                  stg_ready [fdat_pkg::DABBLE_STAGES+1];
    fdat_pkg::dabble_t     stg_data  [fdat_pkg::DABBLE_STAGES+1];
    logic                  fmt_valid;
    logic                  ser_ready;
    fdat_pkg::text_t       fmt_text;
    logic [fdat_pkg::CHAR_W-1:0] out_char;

    assign stg_valid[0]    = s_tvalid;
    assign s_tready        = stg_ready[0];
    assign stg_data[0].bcd = '0;
    assign stg_data[0].bin = s_tdata;

    for (genvar i = 0; i < fdat_pkg::DABBLE_STAGES; i++)
    begin : g_dabble
        fdat_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    fdat_format u_format (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[fdat_pkg::DABBLE_STAGES]),
        .in_ready  (stg_ready[fdat_pkg::DABBLE_STAGES]),
        .in_bcd    (stg_data[fdat_pkg::DABBLE_STAGES].bcd),
        .out_valid (fmt_valid),
        .out_ready (ser_ready),
        .out_text  (fmt_text)
    );

    fdat_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fmt_valid),
        .in_ready  (ser_ready),
        .in_text   (fmt_text),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, out_char};

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_char == fdat_pkg::ASCII_POINT ||
                      (out_char >= fdat_pkg::ASCII_ZERO &&
                       out_char <= fdat_pkg::ASCII_ZERO + 6'd9)))
        else $error("illegal output character");

    a_point_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_char == fdat_pkg::ASCII_POINT) |-> !m_tlast)
        else $error("text ends in a decimal point");

    a_fmt_held: assert property (@(posedge clk) disable iff (!rst_n)
        (fmt_valid && !ser_ready) |=> fmt_valid)
        else $error("formatted request dropped while serializer busy");

endmodule
